FILE: design/bcucr_pkg.sv
// Package with shared constants, command and status types and controller states.
`timescale 1ns / 1ps
`default_nettype none

package bcucr_pkg;

  localparam int CACHED_SLOTS_DEF = 3;
  localparam int NUM_STREAMS_DEF  = 4;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int BLOCK_W  = 32;
  localparam int STREAM_W = 2;
  localparam int SLOT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_REGS = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_REPLACE
  } state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic scan_init;
    logic scan_step;
    logic replace;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic hit;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/block_cache_use_count_replacement.sv
// Top level of the use-count replacement block cache slot allocator.
`timescale 1ns / 1ps
`default_nettype none

// A request carries a block number and a stream number and is taken at a rising
// edge where start is high and busy is low. Each request yields one result:
// hit, slot and bypass path, shown for exactly one cycle with result_valid_o.
// A result is transferred at the edge that ends that cycle; the receiver cannot
// stall it, so it must always be ready.
// For a bypass request or a hit on a cached slot, the lookup cycle registers the
// result, which appears in the cycle after it, when busy has already dropped.
// A miss on the cached slots goes from lookup to the victim search, which walks
// the use counts one slot per cycle, and then on to the refill.
// The configuration port writes one stream boundary per cycle with cfg_we_i and
// must be used only while the block is idle; the block itself does not enforce this.
// Reset clears all slot valid bits and use counts, sets every boundary to all
// ones and returns the controller to idle.

module block_cache_use_count_replacement
  import bcucr_pkg::*;
#(
  parameter int CachedSlots = CACHED_SLOTS_DEF,
  parameter int NumStreams  = NUM_STREAMS_DEF,
  parameter int CountBits   = COUNT_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire  [BLOCK_W-1:0]   block_number_i,
  input  wire  [STREAM_W-1:0]  stream_number_i,
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [BLOCK_W-1:0]   cfg_data_i,
  output logic                 result_valid_o,
  output logic                 hit_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 bypass_path_o
);

  cmd_t cmd;
  sts_t sts;

  bcucr_ctrl #(
    .CachedSlots(CachedSlots)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  bcucr_dp #(
    .CachedSlots(CachedSlots),
    .NumStreams (NumStreams),
    .CountBits  (CountBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .block_number_i (block_number_i),
    .stream_number_i(stream_number_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .bypass_path_o  (bypass_path_o)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_bypass_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && bypass_path_o) |-> (slot_o == SLOT_W'(CachedSlots)))
    else $error("bypass result does not name the bypass slot");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while a request is still in progress");

endmodule

`default_nettype wire

FILE: design/bcucr_ctrl.sv
// Controller state machine sequencing lookup, victim scan and replacement.
`timescale 1ns / 1ps
`default_nettype none

module bcucr_ctrl
  import bcucr_pkg::*;
#(
  parameter int CachedSlots = CACHED_SLOTS_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.bypass || sts_i.hit) begin
          cmd_o.lookup = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = (CachedSlots > 1) ? ST_SCAN : ST_REPLACE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_REPLACE;
        end
      end
      ST_REPLACE: begin
        cmd_o.replace = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/bcucr_dp.sv
// Datapath holding boundaries, slot tags, use counts and the result registers.
`timescale 1ns / 1ps
`default_nettype none

module bcucr_dp
  import bcucr_pkg::*;
#(
  parameter int CachedSlots = CACHED_SLOTS_DEF,
  parameter int NumStreams  = NUM_STREAMS_DEF,
  parameter int CountBits   = COUNT_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [BLOCK_W-1:0]   cfg_data_i,
  input  wire  [BLOCK_W-1:0]   block_number_i,
  input  wire  [STREAM_W-1:0]  stream_number_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 result_valid_o,
  output logic                 hit_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 bypass_path_o
);

  localparam int TotalSlots = CachedSlots + 1;
  localparam int SlotIdxW   = $clog2(CachedSlots + 1);
  localparam int CIdxW      = (CachedSlots > 1) ? $clog2(CachedSlots) : 1;

  logic [BLOCK_W-1:0]   bound_q [CFG_REGS];
  logic [BLOCK_W-1:0]   blk_q;
  logic [STREAM_W-1:0]  strm_q;
  logic [BLOCK_W-1:0]   tag_q   [TotalSlots];
  logic [STREAM_W-1:0]  stag_q  [TotalSlots];
  logic [TotalSlots-1:0] valid_q;
  logic [CountBits-1:0] count_q [CachedSlots];
  logic [CountBits-1:0] best_q;
  logic [CIdxW-1:0]     best_idx_q;
  logic [CIdxW-1:0]     ptr_q;
  logic                 valid_res_q;
  logic                 hit_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 bypass_q;

  logic [TotalSlots-1:0] match;
  logic                  bypass_c;
  logic                  hit_c;
  logic [CIdxW-1:0]      hit_idx;
  logic [CountBits-1:0]  ptr_count;
  logic [SlotIdxW-1:0]   slot_idx;

  always_comb begin
    bypass_c = ({1'b0, strm_q} >= 3'(NumStreams)) || (blk_q >= bound_q[strm_q]);
    for (int i = 0; i < TotalSlots; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == blk_q) && (stag_q[i] == strm_q);
    end
    hit_c   = bypass_c ? match[CachedSlots] : (|match[CachedSlots-1:0]);
    hit_idx = '0;
    for (int i = CachedSlots - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = CIdxW'(i);
      end
    end
    ptr_count = count_q[0];
    for (int i = 0; i < CachedSlots; i++) begin
      if (CIdxW'(i) == ptr_q) begin
        ptr_count = count_q[i];
      end
    end
    slot_idx = bypass_c ? SlotIdxW'(CachedSlots) : SlotIdxW'(hit_idx);
  end

  assign sts_o.bypass    = bypass_c;
  assign sts_o.hit       = hit_c;
  assign sts_o.scan_last = (ptr_q == CIdxW'(CachedSlots - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        bound_q[i] <= '1;
      end
    end else if (cfg_we_i) begin
      bound_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      blk_q  <= block_number_i;
      strm_q <= stream_number_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < CachedSlots; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      if (cmd_i.lookup && bypass_c && !hit_c) begin
        valid_q[CachedSlots] <= 1'b1;
      end
      for (int i = 0; i < CachedSlots; i++) begin
        if (cmd_i.lookup && !bypass_c && match[i] && (count_q[i] != '1)) begin
          count_q[i] <= count_q[i] + 1'b1;
        end
        if (cmd_i.replace && (CIdxW'(i) == best_idx_q)) begin
          count_q[i] <= '0;
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && bypass_c && !hit_c) begin
      tag_q[CachedSlots]  <= blk_q;
      stag_q[CachedSlots] <= strm_q;
    end
    for (int i = 0; i < CachedSlots; i++) begin
      if (cmd_i.replace && (CIdxW'(i) == best_idx_q)) begin
        tag_q[i]  <= blk_q;
        stag_q[i] <= strm_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q     <= count_q[0];
      best_idx_q <= '0;
      ptr_q      <= CIdxW'(1);
    end else if (cmd_i.scan_step) begin
      if (ptr_count < best_q) begin
        best_q     <= ptr_count;
        best_idx_q <= ptr_q;
      end
      ptr_q <= ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_res_q <= 1'b0;
    end else begin
      valid_res_q <= cmd_i.lookup || cmd_i.replace;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q    <= hit_c;
      slot_q   <= SLOT_W'(slot_idx);
      bypass_q <= bypass_c;
    end else if (cmd_i.replace) begin
      hit_q    <= 1'b0;
      slot_q   <= SLOT_W'(best_idx_q);
      bypass_q <= 1'b0;
    end
  end

  assign result_valid_o = valid_res_q;
  assign hit_o          = hit_q;
  assign slot_o         = slot_q;
  assign bypass_path_o  = bypass_q;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the use-count replacement block cache slot allocator.
`timescale 1ns / 1ps

module tb;
  import bcucr_pkg::*;

  localparam int CACHED_SLOTS = CACHED_SLOTS_DEF;
  localparam int NUM_STREAMS  = NUM_STREAMS_DEF;
  localparam int COUNT_BITS   = COUNT_BITS_DEF;
  localparam int REPEAT_HITS  = 20;
  localparam int SETTLE       = CACHED_SLOTS + 6;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [BLOCK_W-1:0]  blk;
    logic [STREAM_W-1:0] strm;
  } block_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              bypass;
  } slot_choice_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [BLOCK_W-1:0]   block_number = '0;
  logic [STREAM_W-1:0]  stream_number = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [BLOCK_W-1:0]   cfg_data = '0;
  logic                 result_valid;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  logic                 bypass_path;

  block_req_t   pending_reqs[$];
  slot_choice_t expected_slots[$];
  logic         took = 1'b0;
  int unsigned  idle_pct = 0;
  int unsigned  err_count = 0;
  int unsigned  cycle_count = 0;

  // Shadow copy of the allocator state.
  logic [BLOCK_W-1:0]    boundary [CFG_REGS];
  logic [BLOCK_W-1:0]    tag_blk [CACHED_SLOTS+1];
  logic [STREAM_W-1:0]   tag_strm [CACHED_SLOTS+1];
  logic                  tag_valid [CACHED_SLOTS+1];
  logic [COUNT_BITS-1:0] use_cnt [CACHED_SLOTS];

  block_cache_use_count_replacement dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .block_number_i  (block_number),
    .stream_number_i (stream_number),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .result_valid_o  (result_valid),
    .hit_o           (hit),
    .slot_o          (slot),
    .bypass_path_o   (bypass_path)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit slot_holds(int s, logic [BLOCK_W-1:0] blk, logic [STREAM_W-1:0] strm);
    return tag_valid[s] && tag_blk[s] == blk && tag_strm[s] == strm;
  endfunction

  task automatic predict_slot(input block_req_t req, output slot_choice_t res);
    int found;
    int victim;
    found = -1;
    victim = 0;
    res = '0;
    if (int'(req.strm) >= NUM_STREAMS) res.bypass = 1'b1;
    else res.bypass = req.blk >= boundary[req.strm];
    if (res.bypass) begin
      res.slot = SLOT_W'(CACHED_SLOTS);
      res.hit = slot_holds(CACHED_SLOTS, req.blk, req.strm);
      victim = CACHED_SLOTS;
    end else begin
      for (int i = CACHED_SLOTS - 1; i >= 0; i--) begin
        if (slot_holds(i, req.blk, req.strm)) found = i;
      end
      if (found >= 0) begin
        res.hit = 1'b1;
        res.slot = SLOT_W'(found);
        if (use_cnt[found] != '1) use_cnt[found] = use_cnt[found] + 1'b1;
      end else begin
        for (int i = 1; i < CACHED_SLOTS; i++) begin
          if (use_cnt[i] < use_cnt[victim]) victim = i;
        end
        res.slot = SLOT_W'(victim);
        use_cnt[victim] = '0;
      end
    end
    if (!res.hit) begin
      tag_blk[victim] = req.blk;
      tag_strm[victim] = req.strm;
      tag_valid[victim] = 1'b1;
    end
  endtask

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  // Driver: holds a request until it is taken, then may idle before the next one.
  always @(negedge clk_i) begin
    logic holding;
    holding = start && !took;
    if (took && pending_reqs.size() > 0) void'(pending_reqs.pop_front());
    if (!holding) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        block_number <= pending_reqs[0].blk;
        stream_number <= pending_reqs[0].strm;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: tracks configuration writes, predicts each transfer and checks results.
  always @(posedge clk_i) begin
    slot_choice_t want;
    block_req_t req;
    took <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (result_valid) begin
        if (expected_slots.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          err_count++;
        end else begin
          want = expected_slots.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
          if (bypass_path !== want.bypass) report_mismatch("bypass_path", bypass_path, want.bypass);
        end
      end
      if (cfg_we) boundary[cfg_idx] = cfg_data;
      if (start && !busy) begin
        req.blk = block_number;
        req.strm = stream_number;
        predict_slot(req, want);
        expected_slots.push_back(want);
      end
    end
  end

  task automatic push_req(logic [BLOCK_W-1:0] blk, logic [STREAM_W-1:0] strm);
    block_req_t req;
    req.blk = blk;
    req.strm = strm;
    pending_reqs.push_back(req);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || start || expected_slots.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_boundaries(logic [BLOCK_W-1:0] b0, logic [BLOCK_W-1:0] b1,
                                  logic [BLOCK_W-1:0] b2, logic [BLOCK_W-1:0] b3);
    logic [BLOCK_W-1:0] vals [CFG_REGS];
    vals[0] = b0;
    vals[1] = b1;
    vals[2] = b2;
    vals[3] = b3;
    for (int i = 0; i < CFG_REGS; i++) begin
      @(negedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Small pool near the stream boundaries so that hits and replacements are frequent.
  function automatic block_req_t random_req();
    block_req_t req;
    int unsigned k;
    if ($urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, 9);
      case (k)
        6: req.blk = 32'h7FFF_FFFF;
        7: req.blk = 32'h8000_0000;
        8: req.blk = 32'hFFFF_FFFE;
        9: req.blk = 32'hFFFF_FFFF;
        default: req.blk = BLOCK_W'(k);
      endcase
      if ($urandom_range(0, 99) < 80) req.strm = STREAM_W'($urandom_range(0, 1));
      else req.strm = STREAM_W'($urandom_range(2, 3));
    end else begin
      req.blk = $urandom;
      req.strm = STREAM_W'($urandom_range(0, 3));
    end
    return req;
  endfunction

  task automatic random_phase(int unsigned idle, int unsigned count);
    idle_pct = idle;
    repeat (count) pending_reqs.push_back(random_req());
    drain();
  endtask

  initial begin
    for (int i = 0; i < CFG_REGS; i++) boundary[i] = '1;
    for (int i = 0; i <= CACHED_SLOTS; i++) begin
      tag_blk[i] = '0;
      tag_strm[i] = '0;
      tag_valid[i] = 1'b0;
    end
    for (int i = 0; i < CACHED_SLOTS; i++) use_cnt[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero tags in an invalid slot must not hit; ties pick the lowest index.
    push_req(32'h0, 2'd0);
    push_req(32'h0, 2'd0);
    push_req(32'h0, 2'd1);
    push_req(32'h0, 2'd2);
    push_req(32'h0, 2'd3);
    push_req(32'hFFFF_FFFF, 2'd3);
    push_req(32'hFFFF_FFFF, 2'd3);
    push_req(32'hFFFF_FFFF, 2'd0);
    push_req(32'hFFFF_FFFE, 2'd0);
    push_req(32'hFFFF_FFFF, 2'd0);
    drain();

    write_boundaries(32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFE);
    push_req(32'h0, 2'd0);
    push_req(32'h0, 2'd1);
    push_req(32'h1, 2'd1);
    push_req(32'h7FFF_FFFF, 2'd2);
    push_req(32'h8000_0000, 2'd2);
    push_req(32'hFFFF_FFFE, 2'd3);
    push_req(32'hFFFF_FFFD, 2'd3);
    push_req(32'hAAAA_AAAA, 2'd3);
    push_req(32'h5555_5555, 2'd3);
    push_req(32'h5555_5555, 2'd3);
    drain();

    // Build up one slot's use count, then force replacements around it.
    push_req(32'h0000_1234, 2'd3);
    repeat (REPEAT_HITS) push_req(32'h0000_1234, 2'd3);
    for (int i = 0; i < 4; i++) push_req(32'h0000_2000 + i, 2'd3);
    push_req(32'h0000_1234, 2'd3);
    drain();

    write_boundaries(32'h3, 32'hFFFF_FFFF, 32'h0, 32'h2);
    random_phase(9, 150);
    write_boundaries($urandom, $urandom, 32'h1, 32'h8000_0000);
    random_phase(83, 150);
    write_boundaries(32'h2, 32'h4, 32'hFFFF_FFFF, 32'h0);
    random_phase(0, 150);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
